>>> rtl/edd_pkg.sv
package edd_pkg;

   // Tangent table: entries 0 to TAN_ENTRIES; entry i holds tan(i / TAN_ENTRIES rad) in unsigned Q16.
   localparam int TAN_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(TAN_ENTRIES + 1);
   localparam int IDX_PROD_W  = 13 + IDX_W;
   localparam int TAN_W       = 17;

   // Field and register widths.
   localparam int CFG_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_W     = 16;

   // Datapath widths.
   localparam int WT_W       = CFG_W + TAN_W;
   localparam int LSQ_W      = 2 * CFG_W;
   localparam int L2_W       = LSQ_W + FRAC_W;
   localparam int DEN_W      = L2_W + 1;
   localparam int DIFF_W     = L2_W + 1;
   localparam int TWO_L_W    = CFG_W + 1;
   localparam int LV_W       = TWO_L_W + FRAC_W;
   localparam int DV_W       = LV_W + 2;
   localparam int PA_W       = 16 + DIFF_W;
   localparam int PV_W       = 16 + DV_W;
   localparam int NA_W       = PA_W - 1;
   localparam int SV_W       = PV_W - 2;
   localparam int NV_W       = SV_W - FRAC_W;
   localparam int DIV_STEPS  = 16;
   localparam int TP_W       = 30;

   // Numerators in the table series stay below 2^48.
   localparam int TAB_NUM_W  = 48;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WHEELBASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_LEFT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_RIGHT = 2'd3;

   typedef logic signed [14:0] angle_type;
   typedef logic signed [15:0] q88_type;
   typedef logic [CFG_W-1:0] cfg_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [TAN_W-1:0] tan_table_type [0:TAN_ENTRIES];
   typedef longint unsigned u64_type;

   // Command fields that travel alongside the arithmetic.
   typedef struct packed {
      logic    left_inner;
      logic    traction;
      q88_type accel;
      q88_type speed;
      q88_type lspeed;
      q88_type rspeed;
   } side_type;

   // One stage of the pipelined restoring dividers.
   typedef struct packed {
      logic                  valid;
      side_type              side;
      logic                  nega;
      logic                  negv;
      logic                  ovf;
      logic [DEN_W-1:0]      den;
      logic [NA_W-1:0]       rem_a;
      logic [NV_W-1:0]       rem_v;
      logic [DIV_STEPS-1:0]  qa;
      logic [DIV_STEPS-1:0]  qv;
   } div_stage_type;

   // Shift-and-subtract quotient used while the table is built.
   function automatic u64_type table_udiv(u64_type n, u64_type d);
      u64_type q, r;
      q = 0;
      r = 0;
      for (int b = TAB_NUM_W - 1; b >= 0; b--) begin
         r = (r << 1) | ((n >> b) & u64_type'(1));
         if (r >= d) begin
            r = r - d;
            q = q | (u64_type'(1) << b);
         end
      end
      return q;
   endfunction

   // Builds the tangent table at elaboration with a Q30 sine and cosine series.
   function automatic tan_table_type build_tan_table();
      tan_table_type tab;
      u64_type x, x2, st, sp, sn, ct, cp, cn, s, c;
      for (int i = 0; i <= TAN_ENTRIES; i++) begin
         x  = table_udiv(u64_type'(i) << 30, u64_type'(TAN_ENTRIES));
         x2 = (x * x) >> 30;
         st = x;
         sp = x;
         sn = 0;
         ct = u64_type'(1) << 30;
         cp = u64_type'(1) << 30;
         cn = 0;
         for (int k = 1; k <= 12; k++) begin
            st = table_udiv((st * x2) >> 30, u64_type'((2 * k) * (2 * k + 1)));
            ct = table_udiv((ct * x2) >> 30, u64_type'((2 * k - 1) * (2 * k)));
            if ((k & 1) != 0) begin
               sn = sn + st;
               cn = cn + ct;
            end else begin
               sp = sp + st;
               cp = cp + ct;
            end
         end
         s = (sp > sn) ? sp - sn : u64_type'(0);
         c = (cp > cn) ? cp - cn : u64_type'(1);
         tab[i] = TAN_W'(table_udiv((s << 16) + (c >> 1), c));
      end
      return tab;
   endfunction

endpackage

>>> rtl/edd_req_if.sv
interface edd_req_if import edd_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type steer_angle;
   q88_type   accel_cmd;
   q88_type   speed_cmd;
   logic      traction_on;
   q88_type   left_wheel_speed;
   q88_type   right_wheel_speed;

   modport source (
      output valid, steer_angle, accel_cmd, speed_cmd, traction_on,
             left_wheel_speed, right_wheel_speed,
      input  ready
   );
   modport sink (
      input  valid, steer_angle, accel_cmd, speed_cmd, traction_on,
             left_wheel_speed, right_wheel_speed,
      output ready
   );
endinterface

>>> rtl/edd_rsp_if.sv
interface edd_rsp_if import edd_pkg::*; ();
   logic    valid;
   logic    ready;
   q88_type left_accel;
   q88_type right_accel;
   q88_type left_speed_target;
   q88_type right_speed_target;

   modport source (
      output valid, left_accel, right_accel, left_speed_target, right_speed_target,
      input  ready
   );
   modport sink (
      input  valid, left_accel, right_accel, left_speed_target, right_speed_target,
      output ready
   );
endinterface

>>> rtl/edd_csr_if.sv
interface edd_csr_if import edd_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   cfg_type     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/electronic_differential_drive_top.sv
// Electronic differential for a two-motor car.
// req_chan carries one drive command per transfer: steering angle, commanded
// acceleration and speed, traction flag and both measured wheel speeds.
// rsp_chan returns one transfer per command: acceleration and speed target for
// each wheel, in command order. csr_chan writes wheelbase, track and the two
// speed-error gains; it is always ready and should be used only while idle.
// The datapath is a 25-stage pipeline: six stages of table lookup, multiply
// and operand setup, sixteen stages of a one-bit-per-stage restoring divider,
// then two stages of sign, saturation and traction correction and the output
// register. One command is accepted every cycle unless the receiver stalls.
// When the receiver stalls, the whole pipeline holds and req_chan.ready falls;
// nothing is dropped or repeated. Reset empties the pipeline and restores the
// registers to wheelbase 1024 mm, track 512 mm and both gains 1.0.
module electronic_differential_drive_top import edd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   edd_req_if.sink    req_chan,
   edd_rsp_if.source  rsp_chan,
   edd_csr_if.sink    csr_chan
);

   localparam tan_table_type TAN_TABLE = build_tan_table();

   function automatic q88_type sat16(input logic signed [23:0] v);
      if (v > 24'sd32767) begin
         return 16'sh7fff;
      end else if (v < -24'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Configuration registers.
   cfg_type wheelbase_ff, track_ff, gain_left_ff, gain_right_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff  <= 12'd1024;
         track_ff      <= 12'd512;
         gain_left_ff  <= 12'd256;
         gain_right_ff <= 12'd256;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_WHEELBASE:  wheelbase_ff  <= csr_chan.data;
            REG_TRACK:      track_ff      <= csr_chan.data;
            REG_GAIN_LEFT:  gain_left_ff  <= csr_chan.data;
            REG_GAIN_RIGHT: gain_right_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // A zero wheelbase is treated as one millimetre.
   cfg_type              leff;
   logic [TWO_L_W-1:0]   two_l;
   assign leff  = (wheelbase_ff == '0) ? CFG_W'(1) : wheelbase_ff;
   assign two_l = {leff, 1'b0};

   // The whole pipeline moves when the output register is free or taken.
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage 1: angle magnitude, clamp and table index.
   logic [14:0]            mag;
   logic [13:0]            magc;
   logic [IDX_PROD_W-1:0]  idx_prod;
   side_type               side_in;
   logic                   s1_valid_ff;
   side_type               s1_side_ff;
   logic [IDX_W-1:0]       s1_idx_ff;

   always_comb begin
      mag      = req_chan.steer_angle[14] ? 15'(-req_chan.steer_angle)
                                          : 15'(req_chan.steer_angle);
      magc     = (mag > 15'd8192) ? 14'd8192 : mag[13:0];
      idx_prod = IDX_PROD_W'(magc) * IDX_PROD_W'(TAN_ENTRIES) + IDX_PROD_W'(4096);
      side_in.left_inner = !req_chan.steer_angle[14];
      side_in.traction   = req_chan.traction_on;
      side_in.accel      = req_chan.accel_cmd;
      side_in.speed      = req_chan.speed_cmd;
      side_in.lspeed     = req_chan.left_wheel_speed;
      side_in.rspeed     = req_chan.right_wheel_speed;
   end

   // Stages 2 to 6 registers.
   logic                     s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   side_type                 s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff, s6_side_ff;
   logic [TAN_W-1:0]         s2_tan_ff;
   logic [WT_W-1:0]          s3_wt_ff;
   logic [LSQ_W-1:0]         s3_lsq_ff;
   logic [DEN_W-1:0]         s4_den_ff, s5_den_ff, s6_den_ff;
   logic signed [DIFF_W-1:0] s4_diff_ff;
   logic signed [DV_W-1:0]   s4_dv_ff;
   logic signed [PA_W-1:0]   s5_pa_ff;
   logic signed [PV_W-1:0]   s5_pv_ff;
   logic [NA_W-1:0]          s6_na_ff;
   logic [NV_W-1:0]          s6_nv_ff;
   logic                     s6_nega_ff, s6_negv_ff;

   // Operand setup: inner-wheel numerators and denominator.
   logic [L2_W-1:0]  l2;
   logic [LV_W-1:0]  l2v;
   logic [PA_W-1:0]  abs_a;
   logic [PV_W-1:0]  abs_v;
   logic [SV_W-1:0]  sum_v;

   always_comb begin
      l2    = {s3_lsq_ff, 16'b0};
      l2v   = {two_l, 16'b0};
      abs_a = s5_pa_ff[PA_W-1] ? PA_W'(-s5_pa_ff) : PA_W'(s5_pa_ff);
      abs_v = s5_pv_ff[PV_W-1] ? PV_W'(-s5_pv_ff) : PV_W'(s5_pv_ff);
      sum_v = abs_v[SV_W-1:0] + SV_W'({leff, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= side_in;
         s1_idx_ff  <= idx_prod[13 +: IDX_W];
         s2_side_ff <= s1_side_ff;
         s2_tan_ff  <= TAN_TABLE[s1_idx_ff];
         s3_side_ff <= s2_side_ff;
         s3_wt_ff   <= WT_W'(track_ff) * WT_W'(s2_tan_ff);
         s3_lsq_ff  <= LSQ_W'(leff) * LSQ_W'(leff);
         s4_side_ff <= s3_side_ff;
         s4_den_ff  <= DEN_W'(l2) + DEN_W'(s3_wt_ff);
         s4_diff_ff <= DIFF_W'(l2) - DIFF_W'(s3_wt_ff);
         s4_dv_ff   <= DV_W'(l2v) - DV_W'(s3_wt_ff);
         s5_side_ff <= s4_side_ff;
         s5_den_ff  <= s4_den_ff;
         s5_pa_ff   <= PA_W'($signed(s4_side_ff.accel)) * PA_W'(s4_diff_ff);
         s5_pv_ff   <= PV_W'($signed(s4_side_ff.speed)) * PV_W'(s4_dv_ff);
         s6_side_ff <= s5_side_ff;
         s6_den_ff  <= s5_den_ff;
         s6_nega_ff <= s5_pa_ff[PA_W-1];
         s6_negv_ff <= s5_pv_ff[PV_W-1];
         s6_na_ff   <= abs_a[NA_W-1:0] + NA_W'(s5_den_ff[DEN_W-1:1]);
         s6_nv_ff   <= sum_v[SV_W-1:FRAC_W];
      end
   end

   // Divider pipeline.
   div_stage_type div_in, div_out;

   always_comb begin
      div_in.valid = s6_valid_ff;
      div_in.side  = s6_side_ff;
      div_in.nega  = s6_nega_ff;
      div_in.negv  = s6_negv_ff;
      div_in.ovf   = 1'b0;
      div_in.den   = s6_den_ff;
      div_in.rem_a = s6_na_ff;
      div_in.rem_v = s6_nv_ff;
      div_in.qa    = '0;
      div_in.qv    = '0;
   end

   edd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .two_l   (two_l),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // Stage 7: sign the quotients, saturate the inner speed, pick the inner wheel.
   logic signed [16:0] ia;
   q88_type            iv;
   logic               s7_valid_ff, s8_valid_ff;
   side_type           s7_side_ff;
   logic signed [16:0] s7_accl_ff, s7_accr_ff, s8_accl_ff, s8_accr_ff;
   q88_type            s7_tgl_ff, s7_tgr_ff, s8_tgl_ff, s8_tgr_ff;
   logic               s8_tc_ff;
   logic signed [TP_W-1:0] s8_pl_ff, s8_pr_ff;

   always_comb begin
      ia = div_out.nega ? -$signed({1'b0, div_out.qa}) : $signed({1'b0, div_out.qa});
      if (div_out.ovf) begin
         iv = div_out.negv ? 16'sh8000 : 16'sh7fff;
      end else if (div_out.negv) begin
         iv = (div_out.qv > 16'd32768) ? 16'sh8000 : 16'(17'd0 - {1'b0, div_out.qv});
      end else begin
         iv = (div_out.qv > 16'd32767) ? 16'sh7fff : div_out.qv;
      end
   end

   // Stage 8: speed error times gain.
   logic signed [16:0] err_l, err_r;
   assign err_l = 17'(s7_tgl_ff) - 17'(s7_side_ff.lspeed);
   assign err_r = 17'(s7_tgr_ff) - 17'(s7_side_ff.rspeed);

   // Output stage: round the correction, add and saturate.
   logic [TP_W-1:0]        mag_l, mag_r;
   logic [TP_W-1:0]        rnd_l, rnd_r;
   logic signed [23:0]     corr_l, corr_r;
   logic signed [23:0]     sum_l, sum_r;

   always_comb begin
      mag_l  = s8_pl_ff[TP_W-1] ? TP_W'(-s8_pl_ff) : TP_W'(s8_pl_ff);
      mag_r  = s8_pr_ff[TP_W-1] ? TP_W'(-s8_pr_ff) : TP_W'(s8_pr_ff);
      rnd_l  = (mag_l + TP_W'(128)) >> 8;
      rnd_r  = (mag_r + TP_W'(128)) >> 8;
      corr_l = s8_pl_ff[TP_W-1] ? -$signed(rnd_l[23:0]) : $signed(rnd_l[23:0]);
      corr_r = s8_pr_ff[TP_W-1] ? -$signed(rnd_r[23:0]) : $signed(rnd_r[23:0]);
      if (!s8_tc_ff) begin
         corr_l = '0;
         corr_r = '0;
      end
      sum_l = 24'(s8_accl_ff) + corr_l;
      sum_r = 24'(s8_accr_ff) + corr_r;
   end

   q88_type left_accel_ff, right_accel_ff, left_tgt_ff, right_tgt_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_side_ff <= div_out.side;
         s7_accl_ff <= div_out.side.left_inner ? ia : 17'(div_out.side.accel);
         s7_accr_ff <= div_out.side.left_inner ? 17'(div_out.side.accel) : ia;
         s7_tgl_ff  <= div_out.side.left_inner ? iv : div_out.side.speed;
         s7_tgr_ff  <= div_out.side.left_inner ? div_out.side.speed : iv;
         s8_tc_ff   <= s7_side_ff.traction;
         s8_accl_ff <= s7_accl_ff;
         s8_accr_ff <= s7_accr_ff;
         s8_tgl_ff  <= s7_tgl_ff;
         s8_tgr_ff  <= s7_tgr_ff;
         s8_pl_ff   <= TP_W'($signed({1'b0, gain_left_ff})) * TP_W'(err_l);
         s8_pr_ff   <= TP_W'($signed({1'b0, gain_right_ff})) * TP_W'(err_r);
         left_accel_ff  <= sat16(sum_l);
         right_accel_ff <= sat16(sum_r);
         left_tgt_ff    <= s8_tgl_ff;
         right_tgt_ff   <= s8_tgr_ff;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_chan.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= div_out.valid;
         s8_valid_ff  <= s7_valid_ff;
         out_valid_ff <= s8_valid_ff;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.left_accel         = left_accel_ff;
   assign rsp_chan.right_accel        = right_accel_ff;
   assign rsp_chan.left_speed_target  = left_tgt_ff;
   assign rsp_chan.right_speed_target = right_tgt_ff;

   // A stalled pipeline keeps every valid bit in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff,
                        s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff,
                        out_valid_ff}))
      else $error("pipeline moved during a stall");

   // An item reaching the divider output lands in stage 7 on the next advance.
   a_div_handoff: assert property (@(posedge clock) disable iff (reset)
      adv && div_out.valid |=> s7_valid_ff)
      else $error("divider result lost");

   // With traction off the correction is zero, so accelerations stay in range.
   a_no_corr: assert property (@(posedge clock) disable iff (reset)
      s8_valid_ff && !s8_tc_ff |-> corr_l == '0 && corr_r == '0)
      else $error("correction applied with traction off");

endmodule

>>> rtl/edd_divider.sv
module edd_divider import edd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [TWO_L_W-1:0]  two_l,
   input  div_stage_type       div_in,
   output div_stage_type       div_out
);

   div_stage_type stg_ff [DIV_STEPS];
   div_stage_type stg_in [DIV_STEPS];

   // One quotient bit per stage for both dividers, most significant bit first.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - k;
      div_stage_type cur;
      logic [NA_W-1:0] trial_a;
      logic [NV_W-1:0] trial_v;

      if (k == 0) begin : g_first
         assign cur = div_in;
      end else begin : g_next
         assign cur = stg_ff[k-1];
      end

      assign trial_a = NA_W'(cur.den) << BIT;
      assign trial_v = NV_W'(two_l) << BIT;

      always_comb begin
         stg_in[k] = cur;
         if (k == 0) begin
            stg_in[k].ovf = cur.rem_v >= (NV_W'(two_l) << DIV_STEPS);
         end
         if (cur.rem_a >= trial_a) begin
            stg_in[k].rem_a  = cur.rem_a - trial_a;
            stg_in[k].qa[BIT] = 1'b1;
         end
         if (cur.rem_v >= trial_v) begin
            stg_in[k].rem_v  = cur.rem_v - trial_v;
            stg_in[k].qv[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign div_out = stg_ff[DIV_STEPS-1];

   // The speed remainder ends below the divisor unless the quotient overflowed.
   a_rem_v: assert property (@(posedge clock) disable iff (reset)
      div_out.valid && !div_out.ovf |-> div_out.rem_v < NV_W'(two_l))
      else $error("speed divider remainder not reduced");

   // The acceleration remainder ends below the denominator.
   a_rem_a: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> div_out.rem_a < NA_W'(div_out.den))
      else $error("acceleration divider remainder not reduced");

   // A scaled acceleration never exceeds the command in magnitude.
   a_quot_a: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> div_out.qa <= 16'd32768)
      else $error("acceleration quotient out of range");

endmodule
